@@ hw/rtl/ascma_pkg.sv @@
// Shared constants, types and state codes of the scaled moving average unit.
package ascma_pkg;

  localparam int WINDOW     = 100;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int ADDR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 16;
  localparam int SUM_W      = 23;
  localparam int PROD_W     = SAMPLE_W + MV_W;
  localparam int MUL_STEP_W = $clog2(SAMPLE_W);
  localparam int DIV_STEP_W = $clog2(MV_W);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [SAMPLE_W-1:0]  ADC_CODE_MAX     = 12'd4095;
  localparam logic [MV_W-1:0]      FULL_SCALE_RESET = 16'd4150;
  localparam logic [REG_IDX_W-1:0] REG_FULL_SCALE   = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_UPDATE,
    ST_AVG_GO,
    ST_AVG,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] num_hi;
    logic [MV_W-1:0]     num_lo;
    logic [SAMPLE_W-1:0] divisor;
  } div_req_t;

endpackage

@@ hw/rtl/ascma_in_if.sv @@
// Input channel carrying one ADC conversion outcome per transfer.
interface ascma_in_if
  import ascma_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                conversion_ok;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output conversion_ok, output raw_sample, input ready);
  modport sink (input valid, input conversion_ok, input raw_sample, output ready);
endinterface

@@ hw/rtl/ascma_out_if.sv @@
// Output channel carrying one averaged voltage per transfer.
interface ascma_out_if
  import ascma_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] average_mv;

  modport source (output valid, output average_mv, input ready);
  modport sink (input valid, input average_mv, output ready);
endinterface

@@ hw/rtl/adc_scaled_moving_average_unit.sv @@
// Top level of the ADC scaled moving average unit.
//
//   Channel  Kind        Role    Payload
//   sample   valid/ready sink    conversion_ok, raw_sample
//   result   valid/ready source  average_mv
//   APB      psel/penable slave  full_scale_mv at byte address 0
//
// A successful conversion passes through a 12-step serial multiplier and
// two 16-step serial divisions before its result is registered.
// A failed conversion skips the arithmetic and goes straight to the result.
// Reset clears the ring fill count, write slot and running sum; the ring
// memory is never cleared, as unfilled entries are never used.
// A result waiting in the output register does not hold up the next input.
module adc_scaled_moving_average_unit
  import ascma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ascma_in_if.sink           sample,
  ascma_out_if.source        result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t              state;
  state_t              state_next;
  logic [MV_W-1:0]     full_scale_mv;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  logic [ADDR_W-1:0]   write_slot;
  logic [CNT_W-1:0]    filled_count;
  logic [MV_W-1:0]     scaled;
  logic [MV_W-1:0]     average;
  logic [MV_W-1:0]     old_entry;
  logic [MV_W-1:0]     ram_q;
  logic                ring_full;
  logic                mul_start;
  logic                mul_done;
  logic [PROD_W-1:0]   product;
  div_req_t            div_req;
  logic                div_done;
  logic [MV_W-1:0]     quotient;
  logic                out_valid;
  logic [MV_W-1:0]     out_data;
  logic                cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_idx == REG_FULL_SCALE) ? {{(PDATA_W - MV_W){1'b0}}, full_scale_mv}
                                                 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_mv <= FULL_SCALE_RESET;
    end else if (cfg_write && reg_idx == REG_FULL_SCALE) begin
      full_scale_mv <= pwdata[MV_W-1:0];
    end
  end

  ascma_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplier   (sample.raw_sample),
    .multiplicand (full_scale_mv),
    .product      (product),
    .done         (mul_done)
  );

  ascma_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .quotient (quotient),
    .done     (div_done)
  );

  ascma_ram #(
    .WIDTH (MV_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (write_slot),
    .wdata (scaled),
    .raddr (write_slot),
    .rdata (ram_q)
  );

  // The ring fills in slot order, so the slot about to be overwritten has
  // been written only once the ring is full.
  assign ring_full        = filled_count == CNT_W'(WINDOW);
  assign old_entry        = ring_full ? ram_q : '0;
  assign running_sum_next = running_sum - {{(SUM_W - MV_W){1'b0}}, old_entry}
                                        + {{(SUM_W - MV_W){1'b0}}, scaled};

  assign sample.ready      = state == ST_IDLE;
  assign result.valid      = out_valid;
  assign result.average_mv = out_data;

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) begin
          if (sample.conversion_ok) begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_req.start   = 1'b1;
          div_req.num_hi  = product[PROD_W-1:MV_W];
          div_req.num_lo  = product[MV_W-1:0];
          div_req.divisor = ADC_CODE_MAX;
          state_next      = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_AVG_GO;
      end
      ST_AVG_GO: begin
        div_req.start   = 1'b1;
        div_req.num_hi  = SAMPLE_W'(running_sum[SUM_W-1:MV_W]);
        div_req.num_lo  = running_sum[MV_W-1:0];
        div_req.divisor = SAMPLE_W'(filled_count);
        state_next      = ST_AVG;
      end
      ST_AVG: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      write_slot   <= '0;
      filled_count <= '0;
    end else if (state == ST_UPDATE) begin
      running_sum <= running_sum_next;
      if (write_slot == ADDR_W'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
      if (!ring_full) begin
        filled_count <= filled_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCALE && div_done) begin
      scaled <= quotient;
    end
    if (state == ST_IDLE) begin
      average <= '0;
    end else if (state == ST_AVG && div_done) begin
      average <= quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || result.ready)) begin
      out_data <= average;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= CNT_W'(WINDOW))
    else $error("fill count exceeds the window");

  a_ring_order: assert property (@(posedge clk) disable iff (rst)
    !ring_full |-> write_slot == filled_count[ADDR_W-1:0])
    else $error("write slot does not follow the fill count");

  a_scaled_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_UPDATE |-> scaled <= full_scale_mv)
    else $error("scaled sample above full scale");

  a_fail_path: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready && !sample.conversion_ok |=> state == ST_DONE)
    else $error("failed conversion did not go straight to the result");

endmodule

@@ hw/rtl/ascma_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ascma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ascma_serial_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ascma_serial_mul
  import ascma_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] multiplier,
  input  logic [MV_W-1:0]     multiplicand,
  output logic [PROD_W-1:0]   product,
  output logic                done
);

  logic                  busy;
  logic [MUL_STEP_W-1:0] cnt;
  logic [MV_W-1:0]       hi;
  logic [SAMPLE_W-1:0]   lo;
  logic [MV_W-1:0]       mcand;
  logic [MV_W:0]         partial;

  assign partial = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_STEP_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= multiplier;
      mcand <= multiplicand;
    end else if (busy) begin
      hi <= partial[MV_W:1];
      lo <= {partial[0], lo[SAMPLE_W-1:1]};
    end
  end

endmodule

@@ hw/rtl/ascma_serial_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module ascma_serial_div
  import ascma_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic [MV_W-1:0] quotient,
  output logic            done
);

  logic                  busy;
  logic [DIV_STEP_W-1:0] cnt;
  logic [SAMPLE_W-1:0]   rem;
  logic [SAMPLE_W-1:0]   dvs;
  logic [MV_W-1:0]       nq;
  logic [SAMPLE_W:0]     trial;
  logic [SAMPLE_W:0]     diff;
  logic                  ge;

  // The upper part of the dividend is below the divisor, so every
  // quotient bit fits the low word that shifts out alongside it.
  assign trial    = {rem, nq[MV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_STEP_W'(MV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num_hi;
      nq  <= req.num_lo;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      nq  <= {nq[MV_W-2:0], ge};
    end
  end

endmodule

@@ verif/ascma_average_monitor.sv @@
// Monitor that predicts each averaged voltage of the unit and compares it with the result channel.
`timescale 1ns / 1ps

module ascma_average_monitor
  import ascma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  ascma_in_if                sample,
  ascma_out_if               result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 failures,
  output int                 outstanding
);

  logic [MV_W-1:0]  ring_mv [WINDOW];
  logic [SUM_W-1:0] window_sum;
  int unsigned      next_slot;
  int unsigned      fill_level;
  logic [MV_W-1:0]  full_scale;
  logic [MV_W-1:0]  averages_due [$];
  logic [MV_W-1:0]  oldest_average;
  int               mismatch_count = 0;
  int               averages_waiting = 0;

  assign failures    = mismatch_count;
  assign outstanding = averages_waiting;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0d, predicted %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic log_conversion(input logic ok, input logic [SAMPLE_W-1:0] raw);
    logic [PROD_W-1:0] product;
    logic [MV_W-1:0]   scaled;
    if (!ok) begin
      averages_due.push_back('0);
    end else begin
      product    = PROD_W'(raw) * PROD_W'(full_scale);
      scaled     = MV_W'(product / PROD_W'(ADC_CODE_MAX));
      window_sum = window_sum - SUM_W'(ring_mv[next_slot]) + SUM_W'(scaled);
      ring_mv[next_slot] = scaled;
      next_slot  = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
      if (fill_level < WINDOW) begin
        fill_level++;
      end
      averages_due.push_back(MV_W'(32'(window_sum) / fill_level));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (ring_mv[i]) ring_mv[i] = '0;
      window_sum = '0;
      next_slot  = 0;
      fill_level = 0;
      full_scale = FULL_SCALE_RESET;
      averages_due.delete();
      averages_waiting <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (averages_due.size() == 0) begin
          report("average_mv with no conversion waiting", 32'(result.average_mv), 0);
        end else begin
          oldest_average = averages_due.pop_front();
          if (result.average_mv !== oldest_average) begin
            report("average_mv", 32'(result.average_mv), 32'(oldest_average));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        log_conversion(sample.conversion_ok, sample.raw_sample);
      end
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_FULL_SCALE) begin
        if (pwrite) begin
          full_scale = pwdata[MV_W-1:0];
        end else if (prdata !== PDATA_W'(full_scale)) begin
          report("full_scale_mv read", prdata, 32'(full_scale));
        end
      end
      averages_waiting <= averages_due.size();
    end
  end

endmodule

@@ verif/tb_adc_scaled_moving_average_unit.sv @@
// Testbench top: drives conversions and full-scale writes into the unit and gives the verdict.
`timescale 1ns / 1ps

module tb_adc_scaled_moving_average_unit;
  import ascma_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
  localparam int HOLD_CYCLES    = 600;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASE_ITEMS    = 80;
  localparam int RANDOM_PHASES  = 5;
  localparam int SETTLE_CYCLES  = 60;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 mismatches;
  int                 outstanding_averages;
  int                 idle_cycles = 0;
  int                 ok_sent = 0;
  int                 timeouts_sent = 0;
  int                 settings_used = 1;
  int                 holds_done = 0;
  bit                 sender_steady = 1'b0;
  bit                 receiver_steady = 1'b0;
  bit                 hold_results = 1'b0;

  ascma_in_if  sample_if ();
  ascma_out_if result_if ();

  adc_scaled_moving_average_unit dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ascma_average_monitor average_check (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample_if),
    .result      (result_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .failures    (mismatches),
    .outstanding (outstanding_averages)
  );

  always #5 clk = ~clk;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ADC_CODE_MAX;
      default: return SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_conversion(input logic ok, input logic [SAMPLE_W-1:0] raw);
    int gap;
    sample_if.valid         <= 1'b1;
    sample_if.conversion_ok <= ok;
    sample_if.raw_sample    <= raw;
    do @(posedge clk); while (!sample_if.ready);
    if (ok) ok_sent++;
    else timeouts_sent++;
    gap = sender_steady ? 0 : idle_length();
    if (gap > 0) begin
      sample_if.valid         <= 1'b0;
      sample_if.conversion_ok <= 1'($urandom);
      sample_if.raw_sample    <= SAMPLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    sample_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding_averages != 0);
  endtask

  task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                            input logic [MV_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_full_scale(input logic [MV_W-1:0] value);
    apb_access(1'b1, REG_FULL_SCALE, value);
    apb_access(1'b0, REG_FULL_SCALE, '0);
    settings_used++;
  endtask

  initial begin
    int run;
    result_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        holds_done++;
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      run = receiver_steady ? 0 : idle_length();
      if (run > 0) begin
        result_if.ready <= 1'b0;
        repeat (run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [MV_W-1:0] full_scale_plan [RANDOM_PHASES];
    logic [MV_W-1:0] scale;
    full_scale_plan = '{16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd4150};
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    sample_if.valid         <= 1'b0;
    sample_if.conversion_ok <= 1'b0;
    sample_if.raw_sample    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_access(1'b0, REG_FULL_SCALE, '0);
    send_conversion(1'b0, '0);
    send_conversion(1'b0, ADC_CODE_MAX);
    send_conversion(1'b1, '0);
    send_conversion(1'b1, ADC_CODE_MAX);
    send_conversion(1'b1, 12'd2048);
    send_conversion(1'b0, 12'hAAA);
    send_conversion(1'b1, 12'd1);
    drain_results();

    set_full_scale(16'hFFFF);
    send_conversion(1'b1, ADC_CODE_MAX);
    send_conversion(1'b1, ADC_CODE_MAX);
    send_conversion(1'b1, '0);
    send_conversion(1'b0, ADC_CODE_MAX);
    drain_results();

    set_full_scale(16'd0);
    send_conversion(1'b1, ADC_CODE_MAX);
    send_conversion(1'b1, 12'h555);
    drain_results();

    apb_access(1'b1, REG_SPARE, 16'h1234);
    apb_access(1'b0, REG_FULL_SCALE, '0);
    send_conversion(1'b1, ADC_CODE_MAX);
    drain_results();

    set_full_scale(16'd1);
    send_conversion(1'b1, ADC_CODE_MAX);
    send_conversion(1'b1, 12'd4094);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      scale = (phase == 3) ? MV_W'($urandom_range(0, 65535)) : full_scale_plan[phase];
      set_full_scale(scale);
      receiver_steady = (phase == 2);
      sender_steady   = (phase == 2);
      if (phase == 1) begin
        sender_steady = 1'b1;
        hold_results  = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 12) sender_steady = 1'b0;
        send_conversion($urandom_range(0, 99) < 85, pick_raw());
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d conversions (%0d successful, %0d timed out) under %0d full-scale settings.",
             ok_sent + timeouts_sent, ok_sent, timeouts_sent, settings_used);
    $display("The %0d-entry window turned over about %0d times; output held back %0d time(s).",
             WINDOW, ok_sent / WINDOW, holds_done);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ascma_pkg.sv
hw/rtl/ascma_in_if.sv
hw/rtl/ascma_out_if.sv
hw/rtl/ascma_ram.sv
hw/rtl/ascma_serial_mul.sv
hw/rtl/ascma_serial_div.sv
hw/rtl/adc_scaled_moving_average_unit.sv
verif/ascma_average_monitor.sv
verif/tb_adc_scaled_moving_average_unit.sv
